// ===== hw/rtl/gqd_pkg.sv =====
// Shared types and constants for the Gray-coded QAM hard-decision demapper.
`timescale 1ns / 1ps

package gqd_pkg;

  // Modulation scheme codes held in the scheme register.
  localparam logic [2:0] SCH_BPSK   = 3'd0;
  localparam logic [2:0] SCH_QPSK   = 3'd1;
  localparam logic [2:0] SCH_QAM16  = 3'd2;
  localparam logic [2:0] SCH_QAM64  = 3'd3;
  localparam logic [2:0] SCH_QAM256 = 3'd4;

  // Level spacing is ((FULL_SCALE / (L - 1)) * STEP_NUM) / STEP_DEN.
  localparam int FULL_SCALE = 32767;
  localparam int STEP_NUM   = 7;
  localparam int STEP_DEN   = 10;

  // Number of bits in one output byte.
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // One decided symbol, right-aligned, with its bit count.
  typedef struct packed {
    logic [7:0] bits;
    logic [3:0] nbits;
  } sym_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] packed_byte;
    logic [3:0] valid_bits;
    logic       last_byte;
  } res_t;

  // Up to two results produced by one sample, in order r0 then r1.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ===== hw/rtl/gqd_slicer.sv =====
// Per-axis slicing against constant thresholds, Gray coding and symbol assembly.
`timescale 1ns / 1ps

module gqd_slicer (
  input  logic               [2:0]  scheme_i,
  input  logic signed        [15:0] re_i,
  input  logic signed        [15:0] im_i,
  output gqd_pkg::sym_t             sym_o
);

  logic [7:0] sym_lane [1:4];

  for (genvar Bpa = 1; Bpa <= 4; Bpa++) begin : g_lane
    localparam int Levels = 1 << Bpa;
    localparam int Step   =
      ((gqd_pkg::FULL_SCALE / (Levels - 1)) * gqd_pkg::STEP_NUM) / gqd_pkg::STEP_DEN;

    // Thermometer codes: bit k set when the sample lies at or above the
    // midpoint between levels k-1 and k.
    logic [Levels:0]  th_re;
    logic [Levels:0]  th_im;
    logic [Bpa-1:0]   idx_re;
    logic [Bpa-1:0]   idx_im;
    logic [Bpa-1:0]   gray_re;
    logic [Bpa-1:0]   gray_im;

    assign th_re[0]      = 1'b1;
    assign th_im[0]      = 1'b1;
    assign th_re[Levels] = 1'b0;
    assign th_im[Levels] = 1'b0;

    for (genvar k = 1; k < Levels; k++) begin : g_thr
      localparam int                 Thr  = (2 * k - Levels) * Step;
      localparam logic signed [15:0] ThrV = 16'(Thr);
      assign th_re[k] = (re_i >= ThrV);
      assign th_im[k] = (im_i >= ThrV);
    end

    // The thermometer edge marks the index; clamping falls out of the ends.
    always_comb begin
      idx_re = '0;
      idx_im = '0;
      for (int k = 0; k < Levels; k++) begin
        if (th_re[k] && !th_re[k+1]) begin
          idx_re = idx_re | Bpa'(k);
        end
        if (th_im[k] && !th_im[k+1]) begin
          idx_im = idx_im | Bpa'(k);
        end
      end
    end

    assign gray_re = idx_re ^ (idx_re >> 1);
    assign gray_im = idx_im ^ (idx_im >> 1);

    assign sym_lane[Bpa] = 8'({gray_re, gray_im});
  end

  always_comb begin
    case (scheme_i)
      gqd_pkg::SCH_QPSK: begin
        sym_o.bits  = sym_lane[1];
        sym_o.nbits = 4'd2;
      end
      gqd_pkg::SCH_QAM16: begin
        sym_o.bits  = sym_lane[2];
        sym_o.nbits = 4'd4;
      end
      gqd_pkg::SCH_QAM64: begin
        sym_o.bits  = sym_lane[3];
        sym_o.nbits = 4'd6;
      end
      gqd_pkg::SCH_QAM256: begin
        sym_o.bits  = sym_lane[4];
        sym_o.nbits = 4'd8;
      end
      default: begin
        // BPSK, and the unused codes behave the same way.
        sym_o.bits  = {7'd0, re_i[15]};
        sym_o.nbits = 4'd1;
      end
    endcase
  end

endmodule

// ===== hw/rtl/gqd_packer.sv =====
// Bit accumulator that packs symbols MSB-first into bytes and flushes on the last sample.
`timescale 1ns / 1ps

module gqd_packer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  gqd_pkg::sym_t  sym_i,
  input  logic           last_i,
  output gqd_pkg::push_t push_o
);

  logic [6:0]  pend_bits_q, pend_bits_d;
  logic [2:0]  pend_cnt_q, pend_cnt_d;

  logic [14:0] acc;
  logic [3:0]  total;
  logic        full;
  logic [2:0]  rem;
  logic [6:0]  left_bits;
  logic [2:0]  left_cnt;
  logic [14:0] part_shift;
  gqd_pkg::res_t full_res;
  gqd_pkg::res_t part_res;
  logic        part;

  always_comb begin
    acc   = ({8'd0, pend_bits_q} << sym_i.nbits) | {7'd0, sym_i.bits};
    total = {1'b0, pend_cnt_q} + sym_i.nbits;
    full  = (total >= gqd_pkg::BYTE_BITS);
    rem   = total[2:0];

    full_res.packed_byte = 8'(acc >> rem);
    full_res.valid_bits  = gqd_pkg::BYTE_BITS;
    full_res.last_byte   = last_i && (rem == 3'd0);

    if (full) begin
      left_bits = acc[6:0] & ((7'd1 << rem) - 7'd1);
      left_cnt  = rem;
    end else begin
      left_bits = acc[6:0];
      left_cnt  = total[2:0];
    end

    part_shift           = {8'd0, left_bits} << (gqd_pkg::BYTE_BITS - {1'b0, left_cnt});
    part_res.packed_byte = part_shift[7:0];
    part_res.valid_bits  = {1'b0, left_cnt};
    part_res.last_byte   = 1'b1;
    part                 = last_i && (left_cnt != 3'd0);

    push_o.r1 = part_res;
    if (full) begin
      push_o.r0 = full_res;
    end else begin
      push_o.r0 = part_res;
    end
    if (!take_i) begin
      push_o.n = 2'd0;
    end else begin
      push_o.n = 2'({1'b0, full} + {1'b0, part});
    end

    if (last_i) begin
      pend_bits_d = '0;
      pend_cnt_d  = '0;
    end else begin
      pend_bits_d = left_bits;
      pend_cnt_d  = left_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else if (take_i) begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

endmodule

// ===== hw/rtl/gqd_outq.sv =====
// Small result queue that takes up to two results per cycle and drives the output channel.
`timescale 1ns / 1ps

module gqd_outq #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gqd_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gqd_pkg::res_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gqd_pkg::res_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_nx;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  // Room for the worst case of two results from one sample.
  assign room_o      = (cnt_q <= CntW'(Depth - 2));

  always_comb begin
    wr_ptr_nx = ptr_inc(wr_ptr_q);
    case (push_i.n)
      2'd1:    wr_ptr_d = wr_ptr_nx;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_nx);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i.n) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/gray_qam_hard_demapper_unit.sv =====
// Top level of the Gray-coded square-QAM hard-decision demapper with byte packing.
`timescale 1ns / 1ps

// The unit takes one complex Q15 sample per input transaction and makes a
// hard decision for BPSK, QPSK, 16-QAM, 64-QAM or 256-QAM as selected by the
// scheme register (codes 5 to 7 act as BPSK); the register may be written only
// while the unit is idle. Each axis is sliced against constant midpoint
// thresholds, clamped to the edge levels, Gray coded, and the I bits are
// placed above the Q bits. Symbol bits are packed MSB-first into bytes; each
// full byte leaves as one output transaction with valid_bits_o equal to 8.
// A sample marked last flushes any leftover bits as a zero-padded partial
// byte with last_byte_o set; if no bits are left, the full byte of that
// sample carries the last flag instead. A sample that completes no byte and
// is not last produces no output. The unit accepts one sample every clock
// cycle while the result queue has room: a sample is held in the input
// register, is decided and packed there, and its bytes are written into a
// result queue of OutDepth entries that drives the output. A last sample
// can yield two bytes; the input stalls only when the queue cannot take two
// more results.
module gray_qam_hard_demapper_unit #(
  parameter int unsigned OutDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_re_i,
  input  logic signed [15:0] sample_im_i,
  input  logic               last_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [7:0]  packed_byte_o,
  output logic        [3:0]  valid_bits_o,
  output logic               last_byte_o
);

  logic [2:0]         scheme_q;
  logic               in_vld_q;
  logic signed [15:0] re_q;
  logic signed [15:0] im_q;
  logic               last_q;

  logic               room;
  logic               proc;
  logic               in_take;
  gqd_pkg::sym_t      sym;
  gqd_pkg::push_t     push;
  gqd_pkg::res_t      head;

  // The held sample is decided and packed in the cycle the queue has room.
  assign proc       = in_vld_q && room;
  assign in_stall_o = in_vld_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q <= gqd_pkg::SCH_BPSK;
    end else if (cfg_we_i) begin
      scheme_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      re_q   <= sample_re_i;
      im_q   <= sample_im_i;
      last_q <= last_sample_i;
    end
  end

  gqd_slicer u_slicer (
    .scheme_i (scheme_q),
    .re_i     (re_q),
    .im_i     (im_q),
    .sym_o    (sym)
  );

  gqd_packer u_packer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (proc),
    .sym_i  (sym),
    .last_i (last_q),
    .push_o (push)
  );

  gqd_outq #(
    .Depth (OutDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign packed_byte_o = head.packed_byte;
  assign valid_bits_o  = head.valid_bits;
  assign last_byte_o   = head.last_byte;

`ifndef SYNTHESIS
  // A sample held back for lack of queue room stays intact in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !proc) |=> (in_vld_q && $stable(re_q) && $stable(im_q) && $stable(last_q)))
    else $error("held input sample changed while waiting for queue room");

  // Only a flushed byte at the end of a stream may be partial.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (valid_bits_o != gqd_pkg::BYTE_BITS)) |-> last_byte_o)
    else $error("partial byte without last flag");

  // Every byte delivered carries between one and eight meaningful bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((valid_bits_o != 4'd0) && (valid_bits_o <= gqd_pkg::BYTE_BITS)))
    else $error("valid bit count out of range");

  // Two results from one sample only happen on the last sample of a stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n == 2'd2) |-> (proc && last_q))
    else $error("double result outside a stream end");
`endif

endmodule

// ===== tb/demap_byte_checker.sv =====
// Checker that predicts and compares the packed bytes of the QAM hard-decision demapper.
`timescale 1ns / 1ps

module demap_byte_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] sample_re_i,
  input  logic signed [15:0] sample_im_i,
  input  logic               last_sample_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic        [7:0]  packed_byte_i,
  input  logic        [3:0]  valid_bits_i,
  input  logic               last_byte_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        bytes_awaited_o
);

  localparam int AxisFullScale = 32767;
  localparam int SpacingNum    = 7;
  localparam int SpacingDen    = 10;
  localparam int ReportLimit   = 10;

  logic [2:0]     scheme;
  logic [6:0]     carry_bits;
  int             carry_count;
  int unsigned    mismatches;
  gqd_pkg::res_t  expected_bytes[$];

  // Nearest of the given number of levels on one axis, ties away from zero.
  function automatic int slice_level(input int levels, input int x);
    int spacing;
    int num;
    int den;
    int idx;
    spacing = ((AxisFullScale / (levels - 1)) * SpacingNum) / SpacingDen;
    num = x + spacing * (levels - 1);
    den = 2 * spacing;
    if (num >= 0) begin
      idx = (num + den / 2) / den;
    end else begin
      idx = -((-num + den / 2) / den);
    end
    if (idx < 0) idx = 0;
    if (idx > levels - 1) idx = levels - 1;
    return idx;
  endfunction

  function automatic gqd_pkg::sym_t decide_symbol(input logic [2:0] sch,
                                                  input logic signed [15:0] re,
                                                  input logic signed [15:0] im);
    gqd_pkg::sym_t s;
    int            axis_bits;
    int            levels;
    int            ii;
    int            qi;
    if (sch >= gqd_pkg::SCH_QPSK && sch <= gqd_pkg::SCH_QAM256) begin
      axis_bits = int'(sch);
      levels    = 1 << axis_bits;
      ii = slice_level(levels, re);
      qi = slice_level(levels, im);
      ii = ii ^ (ii >> 1);
      qi = qi ^ (qi >> 1);
      s.bits  = 8'((ii << axis_bits) | qi);
      s.nbits = 4'(2 * axis_bits);
    end else begin
      // BPSK, and the unused codes that fall back to it.
      s.bits  = {7'd0, re[15]};
      s.nbits = 4'd1;
    end
    return s;
  endfunction

  task automatic pack_symbol(input logic signed [15:0] re, input logic signed [15:0] im,
                             input logic last);
    gqd_pkg::sym_t s;
    logic [14:0]   acc;
    int            total;
    int            rem;
    gqd_pkg::res_t r;
    s     = decide_symbol(scheme, re, im);
    acc   = (15'(carry_bits) << s.nbits) | 15'(s.bits);
    total = carry_count + int'(s.nbits);
    if (total >= 8) begin
      rem           = total - 8;
      r.packed_byte = 8'(acc >> rem);
      r.valid_bits  = gqd_pkg::BYTE_BITS;
      r.last_byte   = last && (rem == 0);
      expected_bytes.push_back(r);
      acc   = acc & ((15'd1 << rem) - 15'd1);
      total = rem;
    end
    if (last) begin
      if (total > 0) begin
        r.packed_byte = 8'(acc << (8 - total));
        r.valid_bits  = 4'(total);
        r.last_byte   = 1'b1;
        expected_bytes.push_back(r);
      end
      carry_bits  = '0;
      carry_count = 0;
    end else begin
      carry_bits  = acc[6:0];
      carry_count = total;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gqd_pkg::res_t want;
    if (!rst_ni) begin
      scheme      = gqd_pkg::SCH_BPSK;
      carry_bits  = '0;
      carry_count = 0;
      mismatches  = 0;
      expected_bytes.delete();
      mismatch_count_o <= 0;
      bytes_awaited_o  <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        pack_symbol(sample_re_i, sample_im_i, last_sample_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          if (mismatches < ReportLimit) begin
            $display("unexpected byte %02h bits %0d last %0b", packed_byte_i, valid_bits_i,
                     last_byte_i);
          end
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (packed_byte_i !== want.packed_byte || valid_bits_i !== want.valid_bits ||
              last_byte_i !== want.last_byte) begin
            if (mismatches < ReportLimit) begin
              $display("byte mismatch: expected %02h bits %0d last %0b, got %02h bits %0d last %0b",
                       want.packed_byte, want.valid_bits, want.last_byte,
                       packed_byte_i, valid_bits_i, last_byte_i);
            end
            mismatches++;
          end
        end
      end
      // The register takes its new value at this edge, after any sample accepted here.
      if (cfg_we_i) scheme = cfg_wdata_i;
      mismatch_count_o <= mismatches;
      bytes_awaited_o  <= expected_bytes.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the demapper testbench: clock, reset, stimulus, back-pressure and the verdict.
`timescale 1ns / 1ps

module testbench;

  // Scheme code outside the defined set; the block treats it as BPSK.
  localparam logic [2:0] SCH_UNUSED_TOP = 3'd7;

  // Cycles allowed after the last expected byte for anything still in flight.
  // A sample is held in the input register and its bytes then pass through the
  // result queue, so this settling time is a comfortable margin.
  localparam int SettleCycles = 8;

  // Hard stop on the cycle count. The slowest correct run is about 700
  // samples, each with a long sender gap and two bytes that wait out heavy
  // receiver stalls, plus a drain at every scheme change; this is many times that.
  localparam int unsigned CycleLimit = 400000;

  localparam int ItemsPerPhase = 175;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we        = 1'b0;
  logic        [2:0]  cfg_wdata     = '0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic signed [15:0] sample_re     = '0;
  logic signed [15:0] sample_im     = '0;
  logic               last_sample   = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic        [7:0]  packed_byte;
  logic        [3:0]  valid_bits;
  logic               last_byte;

  int unsigned mismatch_count;
  int unsigned bytes_awaited;
  int unsigned cycle_count = 0;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int idle_pct  = 0;
  int stall_pct = 0;

  gray_qam_hard_demapper_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .sample_re_i   (sample_re),
    .sample_im_i   (sample_im),
    .last_sample_i (last_sample),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .packed_byte_o (packed_byte),
    .valid_bits_o  (valid_bits),
    .last_byte_o   (last_byte)
  );

  demap_byte_checker byte_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .sample_re_i      (sample_re),
    .sample_im_i      (sample_im),
    .last_sample_i    (last_sample),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .packed_byte_i    (packed_byte),
    .valid_bits_i     (valid_bits),
    .last_byte_i      (last_byte),
    .mismatch_count_o (mismatch_count),
    .bytes_awaited_o  (bytes_awaited)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The receiver decides afresh every cycle whether to hold off the output.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a hung handshake or a missing byte ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one sample and returns in the time step in which it was accepted.
  // Random idle cycles come first, and the payload is held while stalled.
  task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                             input logic last);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    sample_re   <= re;
    sample_im   <= im;
    last_sample <= last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Stops sending until every expected byte has come out, then lets the
  // pipeline settle, since a sample that completes no byte may still be inside.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (bytes_awaited != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The scheme register is only written once the unit has gone idle.
  task automatic set_scheme(input logic [2:0] code);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Axis values lean toward full scale and the region around zero, where the
  // slicer clamps and where the BPSK sign flips; the rest span the full range.
  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // Streams of random length, each under a freshly chosen scheme (the unused
  // codes included) and each closed by a last sample, so the leftover bit
  // count at the flush varies. Every scheme change drains the unit first.
  task automatic random_streams(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      set_scheme(3'($urandom_range(7)));
      len = $urandom_range(1, 20);
      for (int k = 0; k < len; k++) begin
        send_sample(pick_axis(), pick_axis(), k == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, without idling on either side.
    // Eight BPSK decisions fill exactly one byte, so the last flag rides on
    // the full byte and no partial byte follows.
    set_scheme(gqd_pkg::SCH_BPSK);
    send_sample(16'sh8000, 16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 16'sh8000, 1'b0);
    send_sample(-16'sd1, 16'sd0, 1'b0);
    send_sample(16'sd0, -16'sd1, 1'b0);
    send_sample(16'sd1, 16'sd0, 1'b0);
    send_sample(-16'sd2, 16'sd0, 1'b0);
    send_sample(16'sh4000, 16'sd0, 1'b0);
    send_sample(-16'sh4000, 16'sd0, 1'b1);

    // An unused code behaves as BPSK; three bits give a partial byte, and the
    // first two samples complete nothing.
    set_scheme(SCH_UNUSED_TOP);
    send_sample(-16'sd1, 16'sd5, 1'b0);
    send_sample(16'sd1, -16'sd5, 1'b0);
    send_sample(16'sh8000, 16'sd0, 1'b1);

    // QPSK: four leftover bits flushed as a partial byte.
    set_scheme(gqd_pkg::SCH_QPSK);
    send_sample(16'sh8000, 16'sh7FFF, 1'b0);
    send_sample(16'sd0, -16'sd1, 1'b1);

    // 256-QAM at the far corners: both axes clamp to the edge levels.
    set_scheme(gqd_pkg::SCH_QAM256);
    send_sample(16'sh7FFF, 16'sh8000, 1'b0);
    send_sample(16'sh8000, 16'sh7FFF, 1'b1);

    // 64-QAM: the last sample yields a full byte and then a two-bit partial.
    set_scheme(gqd_pkg::SCH_QAM64);
    send_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 16'sh8000, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b1);

    // 16-QAM at the exact midpoints between levels, where rounding goes away
    // from zero, both above and below the zero of the shifted axis.
    set_scheme(gqd_pkg::SCH_QAM16);
    send_sample(-16'sd15290, -16'sd30580, 1'b0);
    send_sample(-16'sd30580, -16'sd15290, 1'b0);
    send_sample(16'sd0, 16'sd15290, 1'b1);

    // Random part in four idling phases.
    random_streams(ItemsPerPhase);
    idle_pct  = 78;
    stall_pct = 0;
    random_streams(ItemsPerPhase);
    idle_pct  = 0;
    stall_pct = 78;
    random_streams(ItemsPerPhase);
    idle_pct  = 23;
    stall_pct = 23;
    random_streams(ItemsPerPhase);

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
